@@ rtl/assert_macros.svh @@
// Assertion macros for the validator RTL.
// Included by scv_back, the module that checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SCV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scv assertion failed");

// Antecedent implies consequent in the next cycle.
`define SCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scv assertion failed");

`endif

@@ rtl/scv_pkg.sv @@
// Types, constants and the CRC byte update for the settings record validator.
// No dependencies; imported by the front end, queue, back end, top level and testbench.
package scv_pkg;

	localparam int MAX_RECORD_BYTES = 262144;
	localparam int SizeW = 19;
	localparam int WordW = 32;
	localparam int LimitW = $clog2(MAX_RECORD_BYTES + 1) + 1;
	localparam logic [LimitW-1:0] MaxRecordLimit = LimitW'(MAX_RECORD_BYTES);

	localparam logic [WordW-1:0] CrcInit = 32'hFFFF_FFFF;
	localparam logic [WordW-1:0] CrcTop  = 32'h8000_0000;
	localparam logic [WordW-1:0] CrcPoly = 32'h04C1_1DB7;

	localparam logic [SizeW-1:0] MaxSizeReset = 19'd1016;

	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	typedef enum logic [0:0] {
		REG_EXPECTED_SIZE = 1'b0,
		REG_MAX_SIZE      = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADSIZE = 2'd1,
		ST_SIZEMIS = 2'd2,
		ST_CRCMIS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_FAIL = 2'd0,
		OP_ARM  = 2'd1,
		OP_DATA = 2'd2
	} op_kind_t;

	// One classified beat travelling from the front end to the back end.
	typedef struct packed {
		op_kind_t         kind;
		status_t          status;
		logic [7:0]       data_byte;
		logic [WordW-1:0] checksum;
	} op_t;

	function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc,
			input logic [7:0] data);
		logic [WordW-1:0] c;
		c = crc ^ {data, 24'h0};
		for (int b = 0; b < 8; b++) begin
			if ((c & CrcTop) != '0) begin
				c = (c << 1) ^ CrcPoly;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/scv_in_if.sv @@
// Input channel of the validator: valid/ready handshake and the item payload.
// Depends on nothing.
interface scv_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  data_byte;
	logic [31:0] stored_size;
	logic [31:0] stored_checksum;

	modport source (output valid, cmd, data_byte, stored_size, stored_checksum, input ready);
	modport sink   (input valid, cmd, data_byte, stored_size, stored_checksum, output ready);
endinterface

@@ rtl/scv_out_if.sv @@
// Result channel of the validator: valid/ready handshake and the result payload.
// Depends on nothing.
interface scv_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] computed_crc;

	modport source (output valid, status, computed_crc, input ready);
	modport sink   (input valid, status, computed_crc, output ready);
endinterface

@@ rtl/scv_front.sv @@
// Front end: takes input beats and classifies them into queue operations.
// Depends on scv_pkg and scv_in_if.
module scv_front
	import scv_pkg::*;
(
	scv_in_if.sink          item,
	input  logic [SizeW-1:0] expected_size,
	input  logic [SizeW-1:0] max_size,
	input  logic            q_full,
	output logic            push,
	output op_t             push_op
);

	logic size_bad;
	logic size_mis;

	always_comb begin
		size_bad = (expected_size == '0) || (expected_size > max_size) ||
			(LimitW'(expected_size) > MaxRecordLimit);
		size_mis = item.stored_size != WordW'(expected_size);
	end

	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	always_comb begin
		push_op.data_byte = item.data_byte;
		push_op.checksum  = item.stored_checksum;
		push_op.status    = ST_OK;
		if (item.cmd) begin
			push_op.kind = OP_DATA;
		end else if (size_bad) begin
			push_op.kind   = OP_FAIL;
			push_op.status = ST_BADSIZE;
		end else if (size_mis) begin
			push_op.kind   = OP_FAIL;
			push_op.status = ST_SIZEMIS;
		end else begin
			push_op.kind = OP_ARM;
		end
	end

endmodule

@@ rtl/scv_queue.sv @@
// Short queue of classified operations between the front and back ends.
// Depends on scv_pkg.
module scv_queue
	import scv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output op_t  head
);

	op_t                  mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] count_q;

	function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
		return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = count_q == QueueCntW'(QueueDepth);
	assign nonempty = count_q != '0;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/scv_back.sv @@
// Back end: runs the CRC over armed data bytes and holds the result register.
// Depends on scv_pkg, scv_out_if and assert_macros.svh.
`include "assert_macros.svh"
module scv_back
	import scv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [SizeW-1:0] expected_size,
	input  logic            q_nonempty,
	input  op_t             head,
	output logic            pop,
	scv_out_if.source       result
);

	logic             armed_q;
	logic [WordW-1:0] crc_q;
	logic [SizeW-1:0] seen_q;
	logic [WordW-1:0] held_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [WordW-1:0] out_crc_q;

	logic [WordW-1:0] crc_next;
	logic [SizeW-1:0] seen_next;
	logic             run_done;

	assign pop       = q_nonempty && (!out_valid_q || result.ready);
	assign crc_next  = crc_byte(crc_q, head.data_byte);
	assign seen_next = seen_q + 1'b1;
	// The run ends once the count reaches or passes the current expected size.
	assign run_done  = seen_next >= expected_size;

	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.computed_crc = out_crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			crc_q       <= CrcInit;
			seen_q      <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (head.kind)
					OP_FAIL: begin
						armed_q     <= 1'b0;
						out_valid_q <= 1'b1;
					end
					OP_ARM: begin
						armed_q <= 1'b1;
						crc_q   <= CrcInit;
						seen_q  <= '0;
						held_q  <= head.checksum;
					end
					OP_DATA: begin
						if (armed_q) begin
							crc_q  <= crc_next;
							seen_q <= seen_next;
							if (run_done) begin
								armed_q     <= 1'b0;
								out_valid_q <= 1'b1;
							end
						end
					end
					default: begin
						armed_q <= armed_q;
					end
				endcase
			end
		end
	end

	// Result payload; only loaded on the beat that raises the result.
	always_ff @(posedge clk) begin
		if (pop && head.kind == OP_FAIL) begin
			out_status_q <= head.status;
			out_crc_q    <= '0;
		end else if (pop && head.kind == OP_DATA && armed_q && run_done) begin
			out_status_q <= (crc_next == held_q) ? ST_OK : ST_CRCMIS;
			out_crc_q    <= crc_next;
		end
	end

	`SCV_ASSERT_NEXT(a_fail_gives_result, clk, arst_n, pop && head.kind == OP_FAIL,
		out_valid_q && !armed_q && out_crc_q == '0)
	`SCV_ASSERT_NEXT(a_run_end_disarms, clk, arst_n,
		pop && head.kind == OP_DATA && armed_q && run_done, out_valid_q && !armed_q)
	`SCV_ASSERT_IMPL(a_pop_only_when_free, clk, arst_n, pop,
		q_nonempty && (!out_valid_q || result.ready))

endmodule

@@ rtl/settings_blob_crc_validator_core.sv @@
// Top level of the settings record validator: configuration registers, front end,
// operation queue and back end. Depends on scv_pkg, scv_in_if, scv_out_if and the submodules.
//
// The block validates a stored settings record. A header beat (cmd 0) is checked against
// expected_size, max_size and the record limit and either yields a bad size or size mismatch
// result or arms a run; the following expected_size data beats (cmd 1) go through an MSB-first
// CRC-32 (polynomial 04C11DB7, initial value all ones, no final xor), and the last one yields
// ok or checksum mismatch with the computed CRC. Data beats while no run is armed are dropped.
// One beat is accepted every clock cycle while the queue has room; the rate is set by the
// back end, which folds one byte into the CRC per cycle unless a result waits to be taken.
// A result is registered after its beat has passed through the queue and is held until taken;
// while it waits, the two-entry queue takes up to two further beats before the input stalls.
// Configuration writes take effect on the next cycle and should be made while the block is idle.
module settings_blob_crc_validator_core
	import scv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_idx,
	input  logic [SizeW-1:0] cfg_wdata,
	scv_in_if.sink          item,
	scv_out_if.source       result
);

	logic [SizeW-1:0] expected_size_q;
	logic [SizeW-1:0] max_size_q;

	logic q_full;
	logic q_nonempty;
	logic push;
	logic pop;
	op_t  push_op;
	op_t  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_size_q <= '0;
			max_size_q      <= MaxSizeReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_EXPECTED_SIZE: expected_size_q <= cfg_wdata;
				REG_MAX_SIZE:      max_size_q      <= cfg_wdata;
				default:           max_size_q      <= max_size_q;
			endcase
		end
	end

	scv_front u_front (
		.item          (item),
		.expected_size (expected_size_q),
		.max_size      (max_size_q),
		.q_full        (q_full),
		.push          (push),
		.push_op       (push_op)
	);

	scv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (head)
	);

	scv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.expected_size (expected_size_q),
		.q_nonempty    (q_nonempty),
		.head          (head),
		.pop           (pop),
		.result        (result)
	);

endmodule

@@ dv/tb_settings_blob_crc_validator_core.sv @@
`timescale 1ns / 1ps
// Testbench for settings_blob_crc_validator_core: directed and random header and data beats,
// with results checked against a record CRC predictor kept in a scoreboard class.
// Depends on scv_pkg, scv_in_if, scv_out_if and the validator RTL.

import scv_pkg::*;

typedef enum logic {
	CMD_HEADER = 1'b0,
	CMD_DATA   = 1'b1
} item_cmd_t;

typedef logic [7:0] byte_q_t[$];

typedef struct packed {
	status_t          status;
	logic [WordW-1:0] crc;
} verdict_t;

// Bit-serial form of the MSB-first update: one polynomial step per data bit.
function automatic logic [WordW-1:0] fold_byte(input logic [WordW-1:0] crc,
		input logic [7:0] b);
	logic feedback;
	for (int i = 7; i >= 0; i--) begin
		feedback = crc[WordW-1] ^ b[i];
		crc = {crc[WordW-2:0], 1'b0};
		if (feedback) begin
			crc = crc ^ CrcPoly;
		end
	end
	return crc;
endfunction

class record_scoreboard;
	logic [SizeW-1:0] want_size;
	logic [SizeW-1:0] sector_cap;
	logic [WordW-1:0] crc_acc;
	logic [WordW-1:0] held_sum;
	logic [SizeW-1:0] byte_count;
	bit               run_live;
	verdict_t         verdict_q[$];
	int               errors;
	int               beats;
	int               by_status[4];

	function new();
		want_size = '0;
		sector_cap = MaxSizeReset;
		crc_acc = CrcInit;
		held_sum = '0;
		byte_count = '0;
		run_live = 1'b0;
		errors = 0;
		beats = 0;
		foreach (by_status[i]) by_status[i] = 0;
	endfunction

	function void write_reg(reg_idx_t idx, logic [SizeW-1:0] value);
		case (idx)
			REG_EXPECTED_SIZE: begin
				want_size = value;
			end
			REG_MAX_SIZE: begin
				sector_cap = value;
			end
			default: begin
				sector_cap = sector_cap;
			end
		endcase
	endfunction

	function int outstanding();
		return verdict_q.size();
	endfunction

	function void note_item(logic cmd, logic [7:0] b, logic [WordW-1:0] ssize,
			logic [WordW-1:0] ssum);
		beats++;
		if (cmd == CMD_HEADER) begin
			// Any header abandons a run in progress, whatever it decides.
			run_live = 1'b0;
			if (want_size == '0 || want_size > sector_cap
					|| int'(want_size) > MAX_RECORD_BYTES) begin
				verdict_q.push_back('{ST_BADSIZE, '0});
			end else if (ssize != WordW'(want_size)) begin
				verdict_q.push_back('{ST_SIZEMIS, '0});
			end else begin
				run_live = 1'b1;
				crc_acc = CrcInit;
				byte_count = '0;
				held_sum = ssum;
			end
		end else if (run_live) begin
			crc_acc = fold_byte(crc_acc, b);
			byte_count = byte_count + 1'b1;
			if (byte_count >= want_size) begin
				run_live = 1'b0;
				verdict_q.push_back('{(crc_acc == held_sum) ? ST_OK : ST_CRCMIS, crc_acc});
			end
		end
	endfunction

	task report(string what);
		$display("MISMATCH %s", what);
		errors++;
	endtask

	task check_result(logic [1:0] st, logic [WordW-1:0] crc);
		verdict_t want;
		if (verdict_q.size() == 0) begin
			report($sformatf("result with none pending: status %0d crc %08h", st, crc));
		end else begin
			want = verdict_q.pop_front();
			if (st !== want.status) begin
				report($sformatf("status %0d, predicted %0d", st, want.status));
			end
			if (crc !== want.crc) begin
				report($sformatf("computed_crc %08h, predicted %08h", crc, want.crc));
			end
			if (st === want.status && crc === want.crc) begin
				by_status[st]++;
			end
		end
	endtask
endclass

module tb_settings_blob_crc_validator_core;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int HOLD_CYCLES   = 300;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	reg_idx_t         cfg_idx;
	logic [SizeW-1:0] cfg_wdata;

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold = 0;

	record_scoreboard sb;

	scv_in_if  item_ch ();
	scv_out_if result_ch ();

	settings_blob_crc_validator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	always #4 clk = ~clk;

	// Input is noted before output so that a same-edge result still finds its prediction.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (item_ch.valid && item_ch.ready) begin
				sb.note_item(item_ch.cmd, item_ch.data_byte, item_ch.stored_size,
					item_ch.stored_checksum);
			end
			if (result_ch.valid && result_ch.ready) begin
				sb.check_result(result_ch.status, result_ch.computed_crc);
			end
		end
	end

	task automatic send_item(item_cmd_t cmd, logic [7:0] b, logic [31:0] ssize,
			logic [31:0] ssum);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= cmd;
		item_ch.data_byte <= b;
		item_ch.stored_size <= ssize;
		item_ch.stored_checksum <= ssum;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
	endtask

	task automatic send_data(logic [7:0] b);
		send_item(CMD_DATA, b, $urandom, $urandom);
	endtask

	task automatic send_record(logic [31:0] ssize, byte_q_t body, bit good_sum);
		logic [31:0] sum;
		sum = CrcInit;
		foreach (body[i]) sum = fold_byte(sum, body[i]);
		if (!good_sum) begin
			sum = sum ^ ($urandom | 32'h1);
		end
		send_item(CMD_HEADER, 8'($urandom), ssize, sum);
		foreach (body[i]) send_data(body[i]);
	endtask

	function automatic byte_q_t random_body(int n);
		byte_q_t q;
		for (int i = 0; i < n; i++) q.push_back(8'($urandom));
		return q;
	endfunction

	// Stop offering beats, wait for every pending result, then let the pipeline settle.
	task automatic quiesce();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [SizeW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (rx_hold > 0) begin
				result_ch.ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = rx_idle ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
		end
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int sent;
		int want;
		int cap;
		int kind;
		int lim;
		int burst;
		byte_q_t body;
		logic [31:0] sum;

		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_EXPECTED_SIZE;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.cmd <= CMD_HEADER;
		item_ch.data_byte <= '0;
		item_ch.stored_size <= '0;
		item_ch.stored_checksum <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. A data beat with no run armed is dropped, and the reset
		// expected size of zero makes the first header a bad size.
		send_data(8'h00);
		send_item(CMD_HEADER, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
		quiesce();
		cfg_write(REG_EXPECTED_SIZE, 19'd3);
		send_item(CMD_HEADER, 8'h00, 32'd4, 32'hFFFF_FFFF);
		body = '{8'h00, 8'hFF, 8'hA5};
		send_record(32'd3, body, 1'b1);
		// A header arriving mid-run drops the run and starts a fresh one.
		body = '{8'h5A};
		send_record(32'd3, body, 1'b0);
		body = '{8'hC3, 8'h3C, 8'h80};
		send_record(32'd3, body, 1'b0);
		quiesce();
		cfg_write(REG_EXPECTED_SIZE, SizeW'(MAX_RECORD_BYTES));
		cfg_write(REG_MAX_SIZE, SizeW'(MAX_RECORD_BYTES));
		body = '{8'h01, 8'h02};
		send_record(32'(MAX_RECORD_BYTES), body, 1'b1);
		send_item(CMD_HEADER, 8'h00, 32'h0, 32'h0);
		quiesce();
		cfg_write(REG_MAX_SIZE, '0);
		send_item(CMD_HEADER, 8'h00, 32'(MAX_RECORD_BYTES), 32'h0);
		quiesce();
		// Beyond the record limit even when the sector would allow it.
		cfg_write(REG_EXPECTED_SIZE, '1);
		cfg_write(REG_MAX_SIZE, '1);
		send_item(CMD_HEADER, 8'h00, 32'h0007_FFFF, 32'h0);
		quiesce();
		// Shrinking the expected size mid-run ends the run on the next byte.
		cfg_write(REG_EXPECTED_SIZE, 19'd3);
		cfg_write(REG_MAX_SIZE, 19'd3);
		sum = CrcInit;
		sum = fold_byte(sum, 8'h11);
		sum = fold_byte(sum, 8'h22);
		sum = fold_byte(sum, 8'h33);
		send_item(CMD_HEADER, 8'h00, 32'd3, sum);
		send_data(8'h11);
		send_data(8'h22);
		quiesce();
		cfg_write(REG_EXPECTED_SIZE, 19'd1);
		send_data(8'h33);

		// Back-pressure: the sink holds off while failing headers pile up behind it.
		quiesce();
		cfg_write(REG_EXPECTED_SIZE, '0);
		tx_idle = 1'b0;
		rx_hold = HOLD_CYCLES;
		sent = 0;
		repeat (40) begin
			send_item(CMD_HEADER, 8'($urandom), $urandom, $urandom);
			sent++;
		end

		while (sent < RANDOM_ITEMS) begin
			quiesce();
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				want = $urandom_range(1, 12);
			end else if (kind == 7) begin
				want = $urandom_range(13, 64);
			end else if (kind == 8) begin
				want = 0;
			end else begin
				want = $urandom_range(65, MAX_RECORD_BYTES);
			end
			case ($urandom_range(0, 3))
				0: cap = $urandom_range(0, MAX_RECORD_BYTES);
				1: cap = want;
				default: cap = $urandom_range(want, MAX_RECORD_BYTES);
			endcase
			cfg_write(REG_EXPECTED_SIZE, SizeW'(want));
			cfg_write(REG_MAX_SIZE, SizeW'(cap));
			tx_idle = ($urandom_range(0, 4) != 0);
			rx_idle = ($urandom_range(0, 4) != 0);
			lim = (want > 64) ? 64 : want;
			repeat (16) begin
				kind = $urandom_range(0, 9);
				if (kind <= 5) begin
					if (want >= 1 && want <= 64) begin
						body = random_body(want);
					end else begin
						body = random_body($urandom_range(0, 4));
					end
					send_record(want, body, 1'($urandom_range(0, 1)));
					sent += body.size() + 1;
				end else if (kind == 6) begin
					send_item(CMD_HEADER, 8'($urandom), $urandom, $urandom);
					sent++;
				end else if (kind == 7) begin
					send_item(CMD_HEADER, 8'($urandom), want ^ (32'h1 << $urandom_range(0, 31)),
						$urandom);
					sent++;
				end else if (kind == 8) begin
					// A run cut short; the next header abandons it.
					body = random_body(lim > 1 ? $urandom_range(0, lim - 1) : 0);
					send_record(want, body, 1'b1);
					sent += body.size() + 1;
				end else begin
					burst = $urandom_range(1, 3);
					repeat (burst) send_data(8'($urandom));
					sent += burst;
				end
			end
		end

		quiesce();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d accepted beats and %0d checked results:", sb.beats,
			sb.by_status[0] + sb.by_status[1] + sb.by_status[2] + sb.by_status[3]);
		$display("  %0d ok, %0d bad size, %0d size mismatch, %0d checksum mismatch.",
			sb.by_status[ST_OK], sb.by_status[ST_BADSIZE], sb.by_status[ST_SIZEMIS],
			sb.by_status[ST_CRCMIS]);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
